/* sv/near_plane_clip_project_unit_assert.svh */
// Assertion macros for the near plane clip and project unit.
// Included by the controller and the datapath; no other dependencies.
`ifndef NEAR_PLANE_CLIP_PROJECT_UNIT_ASSERT_SVH
`define NEAR_PLANE_CLIP_PROJECT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define NPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define NPC_ASSERT(lbl, clk, rst_n, prop)
`define NPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/npc_pkg.sv */
// Shared types and constants for the near plane clip and project unit.
// No dependencies.
`timescale 1ns / 1ps
package npc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int BLEND_BITS = 16;
    localparam int DIV_N_W    = 80;
    localparam int DIV_D_W    = 34;

    localparam logic [16:0] BLEND_ONE = 17'h10000;
    localparam logic [33:0] TERM_CAP  = 34'h2_0000_0000;

    localparam logic [2:0] REG_NEAR     = 3'd0;
    localparam logic [2:0] REG_X_GAIN   = 3'd1;
    localparam logic [2:0] REG_Y_GAIN   = 3'd2;
    localparam logic [2:0] REG_SCREEN_W = 3'd3;
    localparam logic [2:0] REG_SCREEN_H = 3'd4;

    localparam logic [30:0] NEAR_RST   = 31'd655;
    localparam logic [30:0] GAIN_RST   = 31'd65536;
    localparam logic [15:0] SCREEN_W_RST = 16'd640;
    localparam logic [15:0] SCREEN_H_RST = 16'd480;

    typedef struct packed {
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic signed [31:0] view_z;
        logic [15:0]        vertex_id;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic [30:0]        depth;
        logic [15:0]        source_a;
        logic [15:0]        source_b;
        logic [16:0]        blend;
        logic               last;
    } t_out_item;

    typedef enum logic [1:0] {SRC_V, SRC_PA, SRC_PB} t_src;
    typedef enum logic [1:0] {BL_ZERO, BL_TA, BL_TB} t_bsel;

    typedef enum logic [3:0] {
        OP_NONE, OP_XLD, OP_XDIV, OP_XT, OP_XMX, OP_XAX, OP_XAY,
        OP_PM1, OP_PM2, OP_PDIV, OP_PTERM, OP_OUT
    } t_op;

    typedef struct packed {
        t_src       src;
        logic [1:0] vi;
        logic [1:0] sa;
        logic [1:0] sb;
        t_bsel      bsel;
        logic       last;
    } t_emit;

    typedef struct packed {
        logic       load;
        logic [1:0] phase;
        t_op        op;
        logic [1:0] vsel;
        logic       to_b;
        logic       axis;
        t_emit      emit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] behind;
        logic       div_done;
        logic       div_busy;
        logic       out_free;
    } t_status;

endpackage

/* sv/npc_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on npc_pkg.
`timescale 1ns / 1ps
module npc_div
    import npc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DIV_N_W);

    logic               r_busy, r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_D_W-1:0] r_rem, r_dvs;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W:0]   rem_sh, rem_sub;
    logic               ge;

    assign rem_sh  = {r_rem, r_quo[DIV_N_W-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_N_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

/* sv/npc_datapath.sv */
// Datapath: vertex store, configuration registers, clip and projection
// arithmetic and the output register. Depends on npc_pkg and npc_div.
`timescale 1ns / 1ps
`include "near_plane_clip_project_unit_assert.svh"
module npc_datapath
    import npc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_in_item    i_in_item,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_item
);
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vtx;

    logic [30:0] r_near, r_xg, r_yg;
    logic [15:0] r_w, r_h;

    t_vtx        r_vtx [3];
    logic [15:0] r_vid [3];
    t_vtx        vtx_rd;

    logic signed [31:0] r_st_x, r_st_y, r_st_z;
    logic signed [31:0] r_pa_x, r_pa_y, r_pb_x, r_pb_y;
    logic [16:0]        r_ta, r_tb;
    logic               r_den_ok;
    logic signed [50:0] r_prod;
    logic [62:0]        r_m;
    logic [32:0]        r_d;
    logic [78:0]        r_n;
    logic               r_sat;
    logic signed [31:0] r_scr_x, r_scr_y;
    logic [15:0]        r_ida;
    logic               r_ov;
    t_out_item          r_out;

    logic signed [31:0] px, py, pz, coord;
    logic [30:0]        gain;
    logic [15:0]        size;
    logic [31:0]        cabs;
    logic [32:0]        d_val;
    logic signed [33:0] num, den;
    logic               div_start, div_busy, div_done, out_free, out_load;
    logic [DIV_N_W-1:0] div_n, quo;
    logic [DIV_D_W-1:0] div_d;
    logic [33:0]        mag;
    logic signed [34:0] term, cx, cy;
    logic [16:0]        t_new, t_sel;
    logic signed [32:0] dx, dy;
    logic signed [50:0] p_shift;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -35'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    assign vtx_rd = r_vtx[i_cmd.vsel];

    always_comb begin
        case (i_cmd.emit.src)
            SRC_PA: begin
                px = r_pa_x;
                py = r_pa_y;
                pz = $signed({1'b0, r_near});
            end
            SRC_PB: begin
                px = r_pb_x;
                py = r_pb_y;
                pz = $signed({1'b0, r_near});
            end
            default: begin
                px = vtx_rd.x;
                py = vtx_rd.y;
                pz = vtx_rd.z;
            end
        endcase
    end

    assign coord = i_cmd.axis ? py : px;
    assign gain  = i_cmd.axis ? r_yg : r_xg;
    assign size  = i_cmd.axis ? r_h : r_w;
    assign cabs  = coord[31] ? 32'(-coord) : 32'(coord);
    assign d_val = (pz < 32'sd1) ? 33'd2 : {pz, 1'b0};

    always_comb begin
        num = $signed({3'b0, r_near}) - 34'(r_st_z);
        den = 34'(vtx_rd.z) - 34'(r_st_z);
        if (num < 0) begin
            num = -num;
            den = -den;
        end
    end

    assign div_start = (i_cmd.op == OP_XDIV) || (i_cmd.op == OP_PDIV);
    assign div_n = (i_cmd.op == OP_PDIV) ? DIV_N_W'(r_n)
                                         : DIV_N_W'({num[32:0], 16'b0});
    assign div_d = (i_cmd.op == OP_PDIV) ? DIV_D_W'(r_d) : den[DIV_D_W-1:0];

    npc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign t_new = !r_den_ok ? 17'd0
                 : (quo > DIV_N_W'(BLEND_ONE)) ? BLEND_ONE : quo[16:0];
    assign t_sel = i_cmd.to_b ? r_tb : r_ta;
    assign dx = 33'(vtx_rd.x) - 33'(r_st_x);
    assign dy = 33'(vtx_rd.y) - 33'(r_st_y);
    assign p_shift = r_prod >>> BLEND_BITS;

    assign mag  = (r_sat || quo > DIV_N_W'(TERM_CAP)) ? TERM_CAP : quo[33:0];
    assign term = coord[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign cx   = $signed(35'(r_w) << (FRAC_BITS - 1));
    assign cy   = $signed(35'(r_h) << (FRAC_BITS - 1));

    assign out_free = !r_ov || !i_out_stall;
    assign out_load = (i_cmd.op == OP_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RST;
            r_xg   <= GAIN_RST;
            r_yg   <= GAIN_RST;
            r_w    <= SCREEN_W_RST;
            r_h    <= SCREEN_H_RST;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_NEAR:     r_near <= i_cfg_data[30:0];
                    REG_X_GAIN:   r_xg   <= i_cfg_data[30:0];
                    REG_Y_GAIN:   r_yg   <= i_cfg_data[30:0];
                    REG_SCREEN_W: r_w    <= i_cfg_data[15:0];
                    REG_SCREEN_H: r_h    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vtx[i_cmd.phase] <= '{x: i_in_item.view_x, y: i_in_item.view_y,
                                    z: i_in_item.view_z};
            r_vid[i_cmd.phase] <= i_in_item.vertex_id;
        end
        case (i_cmd.op)
            OP_XLD: begin
                r_st_x <= vtx_rd.x;
                r_st_y <= vtx_rd.y;
                r_st_z <= vtx_rd.z;
            end
            OP_XDIV: r_den_ok <= den > 0;
            OP_XT: begin
                if (i_cmd.to_b) begin
                    r_tb <= t_new;
                end else begin
                    r_ta <= t_new;
                end
            end
            OP_XMX: r_prod <= 51'(dx) * $signed(51'({1'b0, t_sel}));
            OP_XAX: begin
                if (i_cmd.to_b) begin
                    r_pb_x <= r_st_x + p_shift[31:0];
                end else begin
                    r_pa_x <= r_st_x + p_shift[31:0];
                end
                r_prod <= 51'(dy) * $signed(51'({1'b0, t_sel}));
            end
            OP_XAY: begin
                if (i_cmd.to_b) begin
                    r_pb_y <= r_st_y + p_shift[31:0];
                end else begin
                    r_pa_y <= r_st_y + p_shift[31:0];
                end
            end
            OP_PM1: begin
                r_m   <= 63'(cabs) * 63'(gain);
                r_d   <= d_val;
                r_ida <= r_vid[i_cmd.emit.sa];
            end
            OP_PM2: begin
                r_n   <= 79'(r_m) * 79'(size);
                r_sat <= {3'b0, r_m} >= {r_d, 33'b0};
            end
            OP_PTERM: begin
                if (i_cmd.axis) begin
                    r_scr_y <= sat32(cy - term);
                end else begin
                    r_scr_x <= sat32(cx + term);
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out.screen_x <= r_scr_x;
            r_out.screen_y <= r_scr_y;
            r_out.depth    <= pz[30:0];
            r_out.source_a <= r_ida;
            r_out.source_b <= r_vid[i_cmd.emit.sb];
            case (i_cmd.emit.bsel)
                BL_TA:   r_out.blend <= r_ta;
                BL_TB:   r_out.blend <= r_tb;
                default: r_out.blend <= 17'd0;
            endcase
            r_out.last <= i_cmd.emit.last;
        end
    end

    assign o_status.behind[0] = r_vtx[0].z <= $signed({1'b0, r_near});
    assign o_status.behind[1] = r_vtx[1].z <= $signed({1'b0, r_near});
    assign o_status.behind[2] = r_vtx[2].z <= $signed({1'b0, r_near});
    assign o_status.div_done  = div_done;
    assign o_status.div_busy  = div_busy;
    assign o_status.out_free  = out_free;

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    `NPC_ASSERT_IMPLY(a_div_start_idle, i_clk, i_rst_n, div_start, !div_busy)
    `NPC_ASSERT_IMPLY(a_ta_range, i_clk, i_rst_n, i_cmd.op == OP_XMX, t_sel <= BLEND_ONE)
    `NPC_ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, i_cmd.load, !div_busy && i_cmd.op == OP_NONE)
endmodule

/* sv/npc_ctrl.sv */
// Controller: sequences vertex loads, edge clipping and per-vertex projection.
// Depends on npc_pkg; drives the datapath through t_cmd.
`timescale 1ns / 1ps
`include "near_plane_clip_project_unit_assert.svh"
module npc_ctrl
    import npc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_XLD, S_XDIV, S_XWAIT, S_XT, S_XMX, S_XAX, S_XAY,
        S_PM1, S_PM2, S_PDIV, S_PWAIT, S_PTERM, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_clip, n_clip, r_one, n_one, r_edge_b, n_edge_b, r_axis, n_axis;
    logic [1:0] r_i0, n_i0, r_ia, n_ia, r_ib, n_ib;
    logic [2:0] r_k, n_k;
    logic [1:0] cnt, i0;
    t_emit      emit;
    logic       k_last;

    assign cnt = 2'({1'b0, i_status.behind[0]} + {1'b0, i_status.behind[1]})
               + 2'(i_status.behind[2]);

    always_comb begin
        if (cnt == 2'd1) begin
            i0 = i_status.behind[0] ? 2'd0 : (i_status.behind[1] ? 2'd1 : 2'd2);
        end else begin
            i0 = !i_status.behind[0] ? 2'd0 : (!i_status.behind[1] ? 2'd1 : 2'd2);
        end
    end

    always_comb begin
        emit = '{src: SRC_V, vi: r_k[1:0], sa: r_k[1:0], sb: r_k[1:0],
                 bsel: BL_ZERO, last: r_k == 3'd2};
        if (r_clip && r_one) begin
            case (r_k)
                3'd1: emit = '{src: SRC_V, vi: r_ia, sa: r_ia, sb: r_ia,
                               bsel: BL_ZERO, last: 1'b0};
                3'd2, 3'd4: emit = '{src: SRC_V, vi: r_ib, sa: r_ib, sb: r_ib,
                                     bsel: BL_ZERO, last: 1'b0};
                3'd5: emit = '{src: SRC_PB, vi: r_ib, sa: r_i0, sb: r_ib,
                               bsel: BL_TB, last: 1'b1};
                default: emit = '{src: SRC_PA, vi: r_ia, sa: r_i0, sb: r_ia,
                                  bsel: BL_TA, last: 1'b0};
            endcase
        end else if (r_clip) begin
            case (r_k)
                3'd1: emit = '{src: SRC_PA, vi: r_ia, sa: r_i0, sb: r_ia,
                               bsel: BL_TA, last: 1'b0};
                3'd2: emit = '{src: SRC_PB, vi: r_ib, sa: r_i0, sb: r_ib,
                               bsel: BL_TB, last: 1'b1};
                default: emit = '{src: SRC_V, vi: r_i0, sa: r_i0, sb: r_i0,
                                  bsel: BL_ZERO, last: 1'b0};
            endcase
        end
    end

    assign k_last = r_k == ((r_clip && r_one) ? 3'd5 : 3'd2);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_clip   = r_clip;
        n_one    = r_one;
        n_edge_b = r_edge_b;
        n_axis   = r_axis;
        n_i0     = r_i0;
        n_ia     = r_ia;
        n_ib     = r_ib;
        n_k      = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_phase == 2'd2) begin
                        n_phase = 2'd0;
                        n_state = S_CLASS;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            S_CLASS: begin
                n_clip   = cnt != 2'd0;
                n_one    = cnt == 2'd1;
                n_i0     = i0;
                n_ia     = (i0 == 2'd2) ? 2'd0 : i0 + 2'd1;
                n_ib     = (i0 == 2'd0) ? 2'd2 : i0 - 2'd1;
                n_edge_b = 1'b0;
                n_k      = 3'd0;
                n_axis   = 1'b0;
                if (cnt == 2'd3) begin
                    n_state = S_IDLE;
                end else if (cnt == 2'd0) begin
                    n_state = S_PM1;
                end else begin
                    n_state = S_XLD;
                end
            end
            S_XLD:   n_state = S_XDIV;
            S_XDIV:  n_state = S_XWAIT;
            S_XWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_XT;
                end
            end
            S_XT:    n_state = S_XMX;
            S_XMX:   n_state = S_XAX;
            S_XAX:   n_state = S_XAY;
            S_XAY: begin
                if (r_edge_b) begin
                    n_state = S_PM1;
                end else begin
                    n_edge_b = 1'b1;
                    n_state  = S_XLD;
                end
            end
            S_PM1:   n_state = S_PM2;
            S_PM2:   n_state = S_PDIV;
            S_PDIV:  n_state = S_PWAIT;
            S_PWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_PTERM;
                end
            end
            S_PTERM: begin
                if (r_axis) begin
                    n_state = S_OUT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_PM1;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_axis = 1'b0;
                    if (k_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 3'd1;
                        n_state = S_PM1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 2'd0;
            r_clip   <= 1'b0;
            r_one    <= 1'b0;
            r_edge_b <= 1'b0;
            r_axis   <= 1'b0;
            r_i0     <= 2'd0;
            r_ia     <= 2'd0;
            r_ib     <= 2'd0;
            r_k      <= 3'd0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_clip   <= n_clip;
            r_one    <= n_one;
            r_edge_b <= n_edge_b;
            r_axis   <= n_axis;
            r_i0     <= n_i0;
            r_ia     <= n_ia;
            r_ib     <= n_ib;
            r_k      <= n_k;
        end
    end

    always_comb begin
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.phase = r_phase;
        o_cmd.to_b  = r_edge_b;
        o_cmd.axis  = r_axis;
        o_cmd.emit  = emit;
        o_cmd.vsel  = emit.vi;
        case (r_state)
            S_XLD:   o_cmd.op = OP_XLD;
            S_XDIV:  o_cmd.op = OP_XDIV;
            S_XT:    o_cmd.op = OP_XT;
            S_XMX:   o_cmd.op = OP_XMX;
            S_XAX:   o_cmd.op = OP_XAX;
            S_XAY:   o_cmd.op = OP_XAY;
            S_PM1:   o_cmd.op = OP_PM1;
            S_PM2:   o_cmd.op = OP_PM2;
            S_PDIV:  o_cmd.op = OP_PDIV;
            S_PTERM: o_cmd.op = OP_PTERM;
            S_OUT:   o_cmd.op = OP_OUT;
            default: o_cmd.op = OP_NONE;
        endcase
        case (r_state)
            S_XLD:   o_cmd.vsel = r_i0;
            S_XDIV, S_XWAIT, S_XT, S_XMX, S_XAX, S_XAY:
                     o_cmd.vsel = r_edge_b ? r_ib : r_ia;
            default: o_cmd.vsel = emit.vi;
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

    `NPC_ASSERT(a_phase_range, i_clk, i_rst_n, r_phase != 2'd3)
    `NPC_ASSERT(a_k_range, i_clk, i_rst_n, r_k <= 3'd5)
    `NPC_ASSERT_IMPLY(a_k_three, i_clk, i_rst_n, r_state == S_OUT && !(r_clip && r_one), r_k <= 3'd2)
endmodule

/* sv/near_plane_clip_project_unit.sv */
// Throughput: one triangle at a time; vertices that do not close a triangle are
// taken without stall, and input then stalls until the last emitted vertex enters
// the output register; output stalls prolong it. A single radix-2 divider is
// shared by clip weights and projections.
// Reset (synchronous, active low) restores register defaults and vertex phase.
`timescale 1ns / 1ps
module near_plane_clip_project_unit
    import npc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    npc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    npc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );
endmodule
